[hw/rtl/rltq_pkg.sv]
// Shared types, codes and defaults for the run-length tag queue.
`timescale 1ns / 1ps
`default_nettype none

package rltq_pkg;

  // Default sizes for the top-level parameters
  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 1024;
  localparam int TAG_BITS_DEF    = 64;
  localparam int MAX_REQUEST_DEF = 64;

  // Refill threshold after reset
  localparam logic [10:0] THR_RESET = 11'd341;

  // Operation codes
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CHECK,
    S_EVAL,
    S_PUT
  } state_t;

  // Input beat
  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  queue_index;
    logic [63:0] run_tag;
    logic [7:0]  run_length;
    logic [6:0]  request_count;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [2:0]  result_queue;
    logic [63:0] piece_tag;
    logic [7:0]  piece_count;
    logic        last_piece;
    logic [1:0]  status;
    logic [10:0] queue_level;
    logic        refill_wanted;
  } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/rltq_store.sv]
// Run store: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rltq_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13,
  parameter int DW    = 72
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write a run entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rltq_engine.sv]
// Sequencer and shared compare/subtract datapath for queue operations.
`timescale 1ns / 1ps
`default_nettype none

module rltq_engine #(
  parameter int NUM_QUEUES  = rltq_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = rltq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = rltq_pkg::TAG_BITS_DEF,
  parameter int MAX_REQUEST = rltq_pkg::MAX_REQUEST_DEF,
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int HW = $clog2(QUEUE_DEPTH),
  localparam int LW = $clog2(QUEUE_DEPTH + 1),
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH),
  localparam int DW = TAG_BITS + 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rltq_pkg::in_item_t  in_data,
  input  wire logic [10:0]         thr,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output rltq_pkg::out_item_t      res_data,
  output logic                     mem_wr_en,
  output logic [AW-1:0]            mem_wr_addr,
  output logic [DW-1:0]            mem_wr_data,
  output logic                     mem_rd_en,
  output logic [AW-1:0]            mem_rd_addr,
  input  wire logic [DW-1:0]       mem_rd_data
);

  rltq_pkg::state_t state_r, state_nxt;

  // Per-queue control state
  logic [HW-1:0] head_r [NUM_QUEUES];
  logic [LW-1:0] lvl_r  [NUM_QUEUES];
  logic          end_r  [NUM_QUEUES];

  // Latched beat and working registers
  logic [1:0]          op_r;
  logic [2:0]          q_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [7:0]          len_r;
  logic [6:0]          remain_r;
  logic [AW-1:0]       base_r;
  logic [TAG_BITS-1:0] piece_tag_r;
  logic [7:0]          piece_cnt_r;
  logic [1:0]          status_r;
  logic                last_r;

  logic [QW-1:0]       qidx;
  logic                q_ok;
  logic [HW-1:0]       cur_head;
  logic [LW-1:0]       cur_lvl;
  logic                cur_end;
  logic                full;
  logic                push_wr;
  logic [LW:0]         tail_sum;
  logic [HW-1:0]       tail;
  logic [HW-1:0]       head_inc;
  logic [6:0]          need_sat;
  logic [7:0]          rd_len;
  logic [TAG_BITS-1:0] rd_tag;
  logic [8:0]          diff;
  logic                fits;

  // Select the addressed queue
  assign qidx     = QW'(q_r);
  assign q_ok     = 32'(q_r) < NUM_QUEUES;
  assign cur_head = head_r[qidx];
  assign cur_lvl  = lvl_r[qidx];
  assign cur_end  = end_r[qidx];
  assign full     = cur_lvl >= LW'(QUEUE_DEPTH);
  assign push_wr  = q_ok && (op_r == rltq_pkg::OP_PUSH) && (len_r != 8'd0) && !full;

  // Tail slot: head plus level, wrapped once
  assign tail_sum = (LW + 1)'(cur_head) + (LW + 1)'(cur_lvl);
  assign tail     = (tail_sum >= (LW + 1)'(QUEUE_DEPTH))
                  ? HW'(tail_sum - (LW + 1)'(QUEUE_DEPTH)) : HW'(tail_sum);
  assign head_inc = (cur_head == HW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;

  // Saturate the request
  assign need_sat = (in_data.request_count > 7'(MAX_REQUEST))
                  ? 7'(MAX_REQUEST) : in_data.request_count;

  // Shared unit: head run length minus units still wanted
  assign rd_len = mem_rd_data[7:0];
  assign rd_tag = mem_rd_data[DW-1:8];
  assign diff   = {1'b0, rd_len} - {2'b00, remain_r};
  assign fits   = diff[8] || (diff == 9'd0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rltq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = rltq_pkg::S_START;
      end
      rltq_pkg::S_START: begin
        if (q_ok && (op_r == rltq_pkg::OP_EXTRACT) && (remain_r != 7'd0)) begin
          state_nxt = rltq_pkg::S_CHECK;
        end else begin
          state_nxt = rltq_pkg::S_PUT;
        end
      end
      rltq_pkg::S_CHECK: begin
        state_nxt = (cur_lvl == '0) ? rltq_pkg::S_PUT : rltq_pkg::S_EVAL;
      end
      rltq_pkg::S_EVAL: begin
        state_nxt = rltq_pkg::S_PUT;
      end
      rltq_pkg::S_PUT: begin
        if (res_ready) state_nxt = last_r ? rltq_pkg::S_IDLE : rltq_pkg::S_CHECK;
      end
      default: state_nxt = rltq_pkg::S_IDLE;
    endcase
  end

  // Handshake and memory strobes; hold the input off while in reset
  always_comb begin
    in_stall    = 1'b1;
    res_valid   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = base_r + AW'(tail);
    mem_wr_data = {tag_r, len_r};
    case (state_r)
      rltq_pkg::S_IDLE:  in_stall = !rst_n;
      rltq_pkg::S_START: mem_wr_en = push_wr;
      rltq_pkg::S_CHECK: mem_rd_en = (cur_lvl != '0);
      rltq_pkg::S_EVAL: begin
        mem_wr_en   = !fits;
        mem_wr_addr = base_r + AW'(cur_head);
        mem_wr_data = {rd_tag, diff[7:0]};
      end
      rltq_pkg::S_PUT:   res_valid = 1'b1;
      default: ;
    endcase
  end

  assign mem_rd_addr = base_r + AW'(cur_head);

  // Advance the sequencer, update queue control state and clear it in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rltq_pkg::S_IDLE;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        lvl_r[i]  <= '0;
        end_r[i]  <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        rltq_pkg::S_START: begin
          if (push_wr) lvl_r[qidx] <= cur_lvl + 1'b1;
          if (q_ok && (op_r == rltq_pkg::OP_END)) end_r[qidx] <= 1'b1;
        end
        rltq_pkg::S_EVAL: begin
          if (fits) begin
            head_r[qidx] <= head_inc;
            lvl_r[qidx]  <= cur_lvl - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Latch the beat and build each result
  always_ff @(posedge clk) begin
    case (state_r)
      rltq_pkg::S_IDLE: begin
        if (in_valid) begin
          op_r     <= in_data.operation;
          q_r      <= in_data.queue_index;
          tag_r    <= in_data.run_tag[TAG_BITS-1:0];
          len_r    <= in_data.run_length;
          remain_r <= need_sat;
          base_r   <= AW'(32'(in_data.queue_index) * QUEUE_DEPTH);
        end
      end
      rltq_pkg::S_START: begin
        piece_tag_r <= '0;
        piece_cnt_r <= 8'd0;
        last_r      <= 1'b1;
        status_r    <= (q_ok && (op_r == rltq_pkg::OP_PUSH) && (len_r != 8'd0) && full)
                     ? rltq_pkg::STAT_FULL : rltq_pkg::STAT_OK;
      end
      rltq_pkg::S_CHECK: begin
        if (cur_lvl == '0) begin
          piece_tag_r <= '0;
          piece_cnt_r <= 8'd0;
          last_r      <= 1'b1;
          status_r    <= rltq_pkg::STAT_SHORT;
        end
      end
      rltq_pkg::S_EVAL: begin
        piece_tag_r <= rd_tag;
        status_r    <= rltq_pkg::STAT_OK;
        if (fits) begin
          piece_cnt_r <= rd_len;
          remain_r    <= 7'(9'd0 - diff);
          last_r      <= (diff == 9'd0);
        end else begin
          piece_cnt_r <= {1'b0, remain_r};
          remain_r    <= 7'd0;
          last_r      <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result beat
  always_comb begin
    res_data.result_queue  = q_r;
    res_data.piece_tag     = 64'(piece_tag_r);
    res_data.piece_count   = piece_cnt_r;
    res_data.last_piece    = last_r;
    res_data.status        = status_r;
    res_data.queue_level   = q_ok ? 11'(cur_lvl) : 11'd0;
    res_data.refill_wanted = q_ok && (32'(cur_lvl) < 32'(thr)) && !cur_end;
  end

endmodule

`default_nettype wire

[hw/rtl/run_length_tag_queue.sv]
// Top level: queue engine, run store, threshold register and output register.
//
//   channel | ports                         | direction
//   input   | in_valid, in_stall, in_data   | beat in, stall out
//   result  | out_valid, out_stall, out_data| beat out, stall in
//   config  | cfg_wr_en, cfg_wr_data        | threshold write
//
// Push, mark-end, odd code, zero request: start step, then result; the next beat is taken once it is handed on.
// Extract: start step, then per piece head check, store read, result; a short end goes from head check to result.
// Reset clears the per-queue head, level and end flags; the store
// is not cleared, only written entries are read.
// A stalled result holds in the output register; the next beat can be accepted
// while it waits, and the next result waits for the register to empty.
`timescale 1ns / 1ps
`default_nettype none

module run_length_tag_queue #(
  parameter int NUM_QUEUES  = rltq_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = rltq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = rltq_pkg::TAG_BITS_DEF,
  parameter int MAX_REQUEST = rltq_pkg::MAX_REQUEST_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rltq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rltq_pkg::out_item_t      out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [10:0]         cfg_wr_data
);

  localparam int SDEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW     = $clog2(SDEPTH);
  localparam int DW     = TAG_BITS + 8;

  logic [10:0]         thr_r;
  logic                out_valid_r;
  rltq_pkg::out_item_t out_data_r;

  logic                res_valid;
  logic                res_ready;
  rltq_pkg::out_item_t res_data;
  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [DW-1:0]       mem_wr_data;
  logic                mem_rd_en;
  logic [AW-1:0]       mem_rd_addr;
  logic [DW-1:0]       mem_rd_data;

  // Hold the refill threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rltq_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rltq_engine #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .MAX_REQUEST (MAX_REQUEST)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .thr         (thr_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  rltq_store #(
    .DEPTH (SDEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire
